### src/rmes_pkg.sv
// Shared types, constants and conversion functions of the register machine step core.
package rmes_pkg;

  localparam int REGISTER_COUNT = 6;
  localparam int DATA_WIDTH     = 32;
  localparam int IDX_W          = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes, decoded from paddr[2]
  localparam logic CFG_IDX_BIND  = 1'b0;
  localparam logic CFG_IDX_BOUND = 1'b1;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [3:0] {
    OP_ADDR = 4'd0,  OP_ADDI = 4'd1,  OP_MULR = 4'd2,  OP_MULI = 4'd3,
    OP_BANR = 4'd4,  OP_BANI = 4'd5,  OP_BORR = 4'd6,  OP_BORI = 4'd7,
    OP_SETR = 4'd8,  OP_SETI = 4'd9,  OP_GTIR = 4'd10, OP_GTRI = 4'd11,
    OP_GTRR = 4'd12, OP_EQIR = 4'd13, OP_EQRI = 4'd14, OP_EQRR = 4'd15
  } opcode_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_MUL, ALU_AND, ALU_OR, ALU_SET, ALU_GT, ALU_EQ
  } alu_op_t;

  typedef struct packed {
    alu_op_t    alu_op;
    logic       a_reg;
    logic       b_reg;
    idx_t       a_idx;
    idx_t       b_idx;
    data_t      a_imm;
    data_t      b_imm;
    logic [2:0] dest;
    logic       err;
  } item_t;

  typedef struct packed {
    logic       bind_en;
    logic [2:0] bound;
  } cfg_t;

  // Sign-extend a 32-bit immediate, then keep the machine width
  function automatic data_t imm_to_data(logic [31:0] raw);
    logic signed [31:0] s;
    logic signed [63:0] w;
    s = raw;
    w = 64'(s);
    return w[DATA_WIDTH-1:0];
  endfunction

  // Sign-extend a machine word, then keep 32 bits for the result port
  function automatic logic [31:0] data_to_out(data_t v);
    logic signed [DATA_WIDTH-1:0] s;
    logic signed [63:0]           w;
    s = v;
    w = 64'(s);
    return w[31:0];
  endfunction

endpackage

### src/rmes_front.sv
// Front end: decode the opcode and range-check the register indexes of an item.
module rmes_front import rmes_pkg::*; (
  input  logic [3:0]         opcode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  input  logic [2:0]         dest_index,
  output item_t              item
);

  logic a_reg, b_reg, a_ok, b_ok, d_ok;
  alu_op_t alu_op;

  always_comb begin
    unique case (opcode) inside
      OP_SETI, OP_GTIR, OP_EQIR: a_reg = 1'b0;
      default:                   a_reg = 1'b1;
    endcase
    unique case (opcode) inside
      OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: b_reg = 1'b1;
      default: b_reg = 1'b0;
    endcase
    unique case (opcode) inside
      OP_ADDR, OP_ADDI:          alu_op = ALU_ADD;
      OP_MULR, OP_MULI:          alu_op = ALU_MUL;
      OP_BANR, OP_BANI:          alu_op = ALU_AND;
      OP_BORR, OP_BORI:          alu_op = ALU_OR;
      OP_SETR, OP_SETI:          alu_op = ALU_SET;
      OP_GTIR, OP_GTRI, OP_GTRR: alu_op = ALU_GT;
      default:                   alu_op = ALU_EQ;
    endcase
  end

  assign a_ok = $unsigned(operand_a) < 32'(REGISTER_COUNT);
  assign b_ok = $unsigned(operand_b) < 32'(REGISTER_COUNT);
  assign d_ok = 32'(dest_index) < 32'(REGISTER_COUNT);

  always_comb begin
    item.alu_op = alu_op;
    item.a_reg  = a_reg;
    item.b_reg  = b_reg;
    item.a_idx  = (a_reg && a_ok) ? IDX_W'($unsigned(operand_a)) : '0;
    item.b_idx  = (b_reg && b_ok) ? IDX_W'($unsigned(operand_b)) : '0;
    item.a_imm  = imm_to_data(operand_a);
    item.b_imm  = imm_to_data(operand_b);
    item.dest   = dest_index;
    item.err    = (a_reg && !a_ok) || (b_reg && !b_ok) || !d_ok;
  end

endmodule

### src/rmes_queue.sv
// Short FIFO of decoded items between the front end and the execute back end.
module rmes_queue import rmes_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  nonempty
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  assign head     = slots[rd_ptr];
  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);

endmodule

### src/rmes_back.sv
// Back end: register file, instruction pointer, execute stage and result register.
module rmes_back import rmes_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               cfg_wr,
  input  logic               q_nonempty,
  input  item_t              q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] next_pointer,
  output logic signed [31:0] written_value,
  output logic [2:0]         written_index,
  output logic               status
);

  data_t mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] vld;
  data_t ip;

  logic  pend_valid;
  idx_t  pend_idx;

  logic  ex_valid;
  item_t ex_item;
  data_t rd_a, rd_b;

  logic  ex_fire, bad, bind_hit_a, bind_hit_b, dest_is_bound;
  idx_t  bidx, didx;
  data_t a, b, r, prod, ip_new;

  logic  wr_en;
  idx_t  wr_idx;
  data_t wr_data;

  assign ex_fire = ex_valid && (!out_valid || !out_stall);
  assign q_pop   = q_nonempty && (!ex_valid || ex_fire);

  assign bidx = IDX_W'(cfg.bound);
  assign didx = IDX_W'(ex_item.dest);
  assign bad  = ex_item.err || (cfg.bind_en && (32'(cfg.bound) >= 32'(REGISTER_COUNT)));

  // While bound, the bound register always reads as the pointer
  assign bind_hit_a = cfg.bind_en && (ex_item.a_idx == bidx);
  assign bind_hit_b = cfg.bind_en && (ex_item.b_idx == bidx);
  assign dest_is_bound = cfg.bind_en && (didx == bidx);

  assign a = !ex_item.a_reg ? ex_item.a_imm : (bind_hit_a ? ip : rd_a);
  assign b = !ex_item.b_reg ? ex_item.b_imm : (bind_hit_b ? ip : rd_b);
  assign prod = a * b;

  always_comb begin
    case (ex_item.alu_op)
      ALU_ADD: r = a + b;
      ALU_MUL: r = prod;
      ALU_AND: r = a & b;
      ALU_OR:  r = a | b;
      ALU_SET: r = a;
      ALU_GT:  r = ($signed(a) > $signed(b)) ? DATA_WIDTH'(1) : '0;
      ALU_EQ:  r = (a == b) ? DATA_WIDTH'(1) : '0;
      default: r = '0;
    endcase
  end

  assign ip_new = (dest_is_bound ? r : ip) + DATA_WIDTH'(1);

  // One write port: the executed result, or the deferred bound-register value
  always_comb begin
    if (ex_fire && !bad) begin
      wr_en   = 1'b1;
      wr_idx  = didx;
      wr_data = r;
    end else begin
      wr_en   = cfg_wr && pend_valid;
      wr_idx  = pend_idx;
      wr_data = ip - DATA_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Registered read with write-through bypass
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ex_item <= q_head;
      if (wr_en && wr_idx == q_head.a_idx) begin
        rd_a <= wr_data;
      end else begin
        rd_a <= vld[q_head.a_idx] ? mem[q_head.a_idx] : '0;
      end
      if (wr_en && wr_idx == q_head.b_idx) begin
        rd_b <= wr_data;
      end else begin
        rd_b <= vld[q_head.b_idx] ? mem[q_head.b_idx] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      if (bad) begin
        next_pointer  <= $signed(data_to_out(ip));
        written_value <= '0;
        written_index <= '0;
        status        <= 1'b1;
      end else begin
        next_pointer  <= $signed(data_to_out(ip_new));
        written_value <= $signed(data_to_out(r));
        written_index <= ex_item.dest;
        status        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire && !bad && cfg.bind_en) begin
      pend_idx <= bidx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      ip         <= '0;
      pend_valid <= 1'b0;
      ex_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_idx] <= 1'b1;
      end
      if (ex_fire && !bad) begin
        ip <= ip_new;
      end
      if (ex_fire && !bad && cfg.bind_en) begin
        pend_valid <= 1'b1;
      end else if (cfg_wr) begin
        pend_valid <= 1'b0;
      end
      if (q_pop) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/register_machine_execute_step_core.sv
// Top level of the register machine step core: config port, front end, queue, back end.
//
// Executes one machine instruction per item on REGISTER_COUNT signed registers plus an
// instruction pointer, and returns exactly one result item per input item. Sustained rate
// is one item per clock while out_stall stays low; the limit is the execute loop in the back
// end, where the register file read, the ALU (including a combinational DATA_WIDTH x
// DATA_WIDTH multiply) and the register write close the loop, with a write-through bypass
// covering back-to-back dependences. From input accept to result valid the item passes
// through the two-entry queue, is popped into the execute stage while its operands are
// read, then lands in the output register. in_stall rises only when the queue is full, so
// the front keeps taking items while a finished result waits.
// Registers reset to zero through per-entry valid bits; there is no clearing pass.
// Configuration: pointer_binding_enable at byte address 0, bound_register at address 4;
// write them only while the core is idle. While binding is on the bound register reads
// as the pointer; its stored copy is written back on the next configuration write.
module register_machine_execute_step_core import rmes_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  input  logic [2:0]         dest_index,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] next_pointer,
  output logic signed [31:0] written_value,
  output logic [2:0]         written_index,
  output logic               status,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg;
  logic  cfg_wr;
  item_t front_item, q_head;
  logic  q_full, q_nonempty, q_pop, push;

  // Config writes complete in the access phase; pready is tied high
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bind_en <= 1'b0;
      cfg.bound   <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        CFG_IDX_BIND:  cfg.bind_en <= pwdata[0];
        CFG_IDX_BOUND: cfg.bound   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_IDX_BIND:  prdata = {31'b0, cfg.bind_en};
      CFG_IDX_BOUND: prdata = {29'b0, cfg.bound};
      default:       prdata = '0;
    endcase
  end

  // Accept whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;

  rmes_front u_front (
    .opcode     (opcode),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .dest_index (dest_index),
    .item       (front_item)
  );

  rmes_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_nonempty)
  );

  rmes_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cfg_wr        (cfg_wr),
    .q_nonempty    (q_nonempty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .next_pointer  (next_pointer),
    .written_value (written_value),
    .written_index (written_index),
    .status        (status)
  );

endmodule

### src/rmes_checker.sv
// Port-level checker for the register machine step core, bound to the top level.
module rmes_checker import rmes_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] next_pointer,
  input logic signed [31:0] written_value,
  input logic [2:0]         written_index,
  input logic               status
);

  // Drop any result during reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pointer) &&
                               $stable(written_value) && $stable(written_index) &&
                               $stable(status))
    else $error("stalled result changed");

  // An error result carries no write
  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> written_value == 32'sd0 && written_index == 3'd0)
    else $error("error result reports a write");

  // A good result names an existing register
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> 32'(written_index) < 32'(REGISTER_COUNT))
    else $error("written index out of range");

endmodule

bind register_machine_execute_step_core rmes_checker u_rmes_checker (.*);
